[hdl/pgg_pkg.sv]
// Package: shared types and constants of the polar Gaussian generator.
package pgg_pkg;

  localparam int unsigned UNIFORM_BITS = 16;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned WORK_BITS    = 28;
  localparam int unsigned MAG_W        = UNIFORM_BITS + 1;   // |u| up to 2^F
  localparam int unsigned SQ_W         = 2 * MAG_W;          // u^2, s before reject
  localparam int unsigned S_W          = 2 * FRAC_BITS;      // accepted s
  localparam int unsigned MANT_W       = WORK_BITS + 1;
  localparam int unsigned QUO_W        = WORK_BITS + 1;
  localparam int unsigned EXP_W        = 6;
  localparam int unsigned N_W          = 35;                 // -2 ln s
  localparam int unsigned N_LO_W       = 18;
  localparam int unsigned RAD_W        = 40;                 // sqrt radicand
  localparam int unsigned ROOT_W       = RAD_W / 2;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned LOG_STEPS    = WORK_BITS;

  localparam logic [UNIFORM_BITS-1:0] UMAX = '1;
  localparam logic [27:0] LN2_W = 28'd186065279;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STD_SCALE   = 8'd1;

  typedef struct packed {
    logic [UNIFORM_BITS-1:0] u_sample;
    logic [UNIFORM_BITS-1:0] v_sample;
  } pgg_in_t;

  typedef struct packed {
    logic signed [31:0] gauss_value;
    logic               last_of_pair;
  } pgg_out_t;

  // state carried through the log / divide stages
  typedef struct packed {
    logic [MANT_W-1:0]    mant;
    logic [WORK_BITS-1:0] frac;
    logic [EXP_W-1:0]     kexp;
    logic [S_W-1:0]       s;
    logic [S_W-1:0]       rem_u;
    logic [S_W-1:0]       rem_v;
    logic [QUO_W-1:0]     quo_u;
    logic [QUO_W-1:0]     quo_v;
    logic                 neg_u;
    logic                 neg_v;
  } pgg_iter_t;

  // state carried through the square root stages
  typedef struct packed {
    logic [RAD_W-1:0]  rad_u;
    logic [RAD_W-1:0]  rad_v;
    logic [ROOT_W-1:0] root_u;
    logic [ROOT_W-1:0] root_v;
    logic              neg_u;
    logic              neg_v;
  } pgg_sqrt_t;

endpackage

[hdl/pgg_log_div_stage.sv]
// One stage: a log2 squaring step on the mantissa and a divide step per lane.
module pgg_log_div_stage import pgg_pkg::*; #(
  parameter int unsigned STEP = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  pgg_iter_t dat_i,
  output logic      vld_o,
  output pgg_iter_t dat_o
);

  logic              vld_q;
  pgg_iter_t         dat_q, dat_d;
  logic [2*MANT_W-1:0] prod;
  logic [MANT_W:0]     sq;
  logic [S_W:0]        rem2_u, rem2_v;

  always_comb begin
    dat_d  = dat_i;
    prod   = dat_i.mant * dat_i.mant;
    sq     = prod[2*MANT_W-1:WORK_BITS];
    if (sq[MANT_W]) begin
      dat_d.mant = sq[MANT_W:1];
      dat_d.frac[WORK_BITS-STEP] = 1'b1;
    end else begin
      dat_d.mant = sq[MANT_W-1:0];
    end
    rem2_u = {dat_i.rem_u, 1'b0};
    rem2_v = {dat_i.rem_v, 1'b0};
    if (rem2_u >= {1'b0, dat_i.s}) begin
      dat_d.rem_u = S_W'(rem2_u - {1'b0, dat_i.s});
      dat_d.quo_u = {dat_i.quo_u[QUO_W-2:0], 1'b1};
    end else begin
      dat_d.rem_u = rem2_u[S_W-1:0];
      dat_d.quo_u = {dat_i.quo_u[QUO_W-2:0], 1'b0};
    end
    if (rem2_v >= {1'b0, dat_i.s}) begin
      dat_d.rem_v = S_W'(rem2_v - {1'b0, dat_i.s});
      dat_d.quo_v = {dat_i.quo_v[QUO_W-2:0], 1'b1};
    end else begin
      dat_d.rem_v = rem2_v[S_W-1:0];
      dat_d.quo_v = {dat_i.quo_v[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

[hdl/pgg_sqrt_stage.sv]
// One stage of the digit-by-digit square root: decides one root bit per lane.
module pgg_sqrt_stage import pgg_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  pgg_sqrt_t dat_i,
  output logic      vld_o,
  output pgg_sqrt_t dat_o
);

  logic      vld_q;
  pgg_sqrt_t dat_q, dat_d;
  logic [RAD_W:0] trial_u, trial_v;

  always_comb begin
    dat_d   = dat_i;
    // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
    trial_u = ((RAD_W+1)'(dat_i.root_u) << (BIT + 1)) + ((RAD_W+1)'(1) << (2 * BIT));
    trial_v = ((RAD_W+1)'(dat_i.root_v) << (BIT + 1)) + ((RAD_W+1)'(1) << (2 * BIT));
    if ({1'b0, dat_i.rad_u} >= trial_u) begin
      dat_d.rad_u       = RAD_W'({1'b0, dat_i.rad_u} - trial_u);
      dat_d.root_u[BIT] = 1'b1;
    end
    if ({1'b0, dat_i.rad_v} >= trial_v) begin
      dat_d.rad_v       = RAD_W'({1'b0, dat_i.rad_v} - trial_v);
      dat_d.root_v[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

[hdl/pgg_pair_out.sv]
// Output buffer: holds one finished pair and hands it out as two items.
module pgg_pair_out import pgg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pair_vld_i,
  input  logic signed [31:0] gu_i,
  input  logic signed [31:0] gv_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pgg_out_t           out_item_o
);

  logic               full_q, full_d;
  logic               sel_q, sel_d;
  logic signed [31:0] gu_q, gv_q;
  logic               fire, load;

  assign fire   = full_q && !out_stall_i;
  assign take_o = !full_q || (fire && sel_q);
  assign load   = pair_vld_i && take_o;

  always_comb begin
    full_d = full_q;
    sel_d  = sel_q;
    if (fire) begin
      if (sel_q) begin
        full_d = 1'b0;
      end
      sel_d = !sel_q;
    end
    if (load) begin
      full_d = 1'b1;
      sel_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      sel_q  <= 1'b0;
    end else begin
      full_q <= full_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      gu_q <= gu_i;
      gv_q <= gv_i;
    end
  end

  assign out_valid_o             = full_q;
  assign out_item_o.gauss_value  = sel_q ? gv_q : gu_q;
  assign out_item_o.last_of_pair = sel_q;

endmodule

[hdl/polar_gaussian_generator_core.sv]
// Top level: Marsaglia polar Gaussian generator, Q16.16, fully pipelined.
// 57 register stages lie between an accepted pair and the output buffer,
//   which registers the pair and shows its u item first, then its v item.
// One result channel; the buffer takes a pair if empty or as its v item goes.
// Rejected pairs (s == 0 or s >= 1) leave the pipe as bubbles, no items.
// Reset: async active low; clears valid bits, mean_offset = 0, std_scale = 1.0.
module polar_gaussian_generator_core import pgg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pgg_in_t              in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pgg_out_t             out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [31:0] mean_q;
  logic [31:0]        std_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= 32'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MEAN_OFFSET: mean_q <= cfg_data_i;
        REG_STD_SCALE:   std_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: the whole pipe moves unless the last stage is full
  // and the output buffer cannot take its pair.
  // ---------------------------------------------------------------------
  logic en;
  logic o_vld_q;
  logic take;

  assign en         = !o_vld_q || take;
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------
  // Stage 1: map uniform words onto signed magnitudes.
  // With FRAC_BITS == UNIFORM_BITS, floor((a*2^(F+1)+M)/(2M)) reduces to
  // a + (2a >= M), so no divider is needed.
  // ---------------------------------------------------------------------
  logic                    m_vld_q;
  logic [MAG_W-1:0]        m_mag_u_q, m_mag_v_q;
  logic                    m_neg_u_q, m_neg_v_q;
  logic [UNIFORM_BITS:0]   a_u, a_v;
  logic                    n_u, n_v;

  always_comb begin
    n_u = {in_item_i.u_sample, 1'b0} < {1'b0, UMAX};
    n_v = {in_item_i.v_sample, 1'b0} < {1'b0, UMAX};
    a_u = n_u ? ({1'b0, UMAX} - {in_item_i.u_sample, 1'b0})
              : ({in_item_i.u_sample, 1'b0} - {1'b0, UMAX});
    a_v = n_v ? ({1'b0, UMAX} - {in_item_i.v_sample, 1'b0})
              : ({in_item_i.v_sample, 1'b0} - {1'b0, UMAX});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mag_u_q <= a_u + MAG_W'({a_u, 1'b0} >= {2'b0, UMAX});
      m_mag_v_q <= a_v + MAG_W'({a_v, 1'b0} >= {2'b0, UMAX});
      m_neg_u_q <= n_u;
      m_neg_v_q <= n_v;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares, s = u^2 + v^2, reject test.
  // ---------------------------------------------------------------------
  logic              q_vld_q;
  logic [S_W-1:0]    q_sqa_q, q_s_q;
  logic              q_neg_u_q, q_neg_v_q;
  logic [SQ_W-1:0]   sqa, sqb;
  logic [SQ_W:0]     ssum;
  logic              keep;

  always_comb begin
    sqa  = m_mag_u_q * m_mag_u_q;
    sqb  = m_mag_v_q * m_mag_v_q;
    ssum = {1'b0, sqa} + {1'b0, sqb};
    keep = (ssum != '0) && (ssum < ((SQ_W+1)'(1) << S_W));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else if (en) begin
      q_vld_q <= m_vld_q && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_sqa_q   <= sqa[S_W-1:0];
      q_s_q     <= ssum[S_W-1:0];
      q_neg_u_q <= m_neg_u_q;
      q_neg_v_q <= m_neg_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: normalize s to a mantissa in [1,2), first divide step.
  // u^2 <= s, so the integer quotient bit is 1 only when v == 0.
  // ---------------------------------------------------------------------
  logic                   p_vld_q;
  pgg_iter_t              p_dat_q, p_dat_d;
  logic [EXP_W-1:0]       lead;
  logic [S_W+WORK_BITS-1:0] shifted;
  logic [S_W-1:0]         sqv;

  always_comb begin
    lead = '0;
    for (int i = 0; i < S_W; i++) begin
      if (q_s_q[i]) begin
        lead = EXP_W'(i);
      end
    end
    shifted = {q_s_q, {WORK_BITS{1'b0}}} >> lead;
    sqv     = q_s_q - q_sqa_q;
    p_dat_d.mant  = shifted[MANT_W-1:0];
    p_dat_d.frac  = '0;
    p_dat_d.kexp  = EXP_W'(S_W) - lead;
    p_dat_d.s     = q_s_q;
    p_dat_d.neg_u = q_neg_u_q;
    p_dat_d.neg_v = q_neg_v_q;
    if (q_sqa_q >= q_s_q) begin
      p_dat_d.quo_u = QUO_W'(1);
      p_dat_d.rem_u = q_sqa_q - q_s_q;
    end else begin
      p_dat_d.quo_u = '0;
      p_dat_d.rem_u = q_sqa_q;
    end
    if (sqv >= q_s_q) begin
      p_dat_d.quo_v = QUO_W'(1);
      p_dat_d.rem_v = sqv - q_s_q;
    end else begin
      p_dat_d.quo_v = '0;
      p_dat_d.rem_v = sqv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (en) begin
      p_vld_q <= q_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dat_q <= p_dat_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 4..31: log2 fraction by repeated squaring, u^2/s and v^2/s
  // by restoring division, one bit of each per stage.
  // ---------------------------------------------------------------------
  logic      it_vld [LOG_STEPS+1];
  pgg_iter_t it_dat [LOG_STEPS+1];

  assign it_vld[0] = p_vld_q;
  assign it_dat[0] = p_dat_q;

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_logdiv
    pgg_log_div_stage #(.STEP(g + 1)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (it_vld[g]),
      .dat_i  (it_dat[g]),
      .vld_o  (it_vld[g+1]),
      .dat_o  (it_dat[g+1])
    );
  end

  pgg_iter_t it_end;
  assign it_end = it_dat[LOG_STEPS];

  // ---------------------------------------------------------------------
  // Stages 32, 33: N = -2 ln s = (k*2^28 - frac) * ln2 / 2^27,
  // split as k*C*2^28 - frac*C.
  // ---------------------------------------------------------------------
  logic                   c_vld_q;
  logic [EXP_W+27:0]      c_kc_q;
  logic [2*WORK_BITS-1:0] c_fc_q;
  logic [QUO_W-1:0]       c_qu_q, c_qv_q;
  logic                   c_neg_u_q, c_neg_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= it_vld[LOG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_kc_q    <= it_end.kexp * LN2_W;
      c_fc_q    <= it_end.frac * LN2_W;
      c_qu_q    <= it_end.quo_u;
      c_qv_q    <= it_end.quo_v;
      c_neg_u_q <= it_end.neg_u;
      c_neg_v_q <= it_end.neg_v;
    end
  end

  logic                       l_vld_q;
  logic [N_W-1:0]             l_n_q;
  logic [QUO_W-1:0]           l_qu_q, l_qv_q;
  logic                       l_neg_u_q, l_neg_v_q;
  logic [EXP_W+28+WORK_BITS-1:0] ln_full;

  assign ln_full = {c_kc_q, {WORK_BITS{1'b0}}} - (EXP_W+28+WORK_BITS)'(c_fc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_vld_q <= 1'b0;
    end else if (en) begin
      l_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_n_q     <= ln_full[WORK_BITS-1+N_W-1:WORK_BITS-1];
      l_qu_q    <= c_qu_q;
      l_qv_q    <= c_qv_q;
      l_neg_u_q <= c_neg_u_q;
      l_neg_v_q <= c_neg_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 34, 35: r*N in two partial products per lane, then >> (56-2F).
  // ---------------------------------------------------------------------
  localparam int unsigned N_HI_W = N_W - N_LO_W;
  localparam int unsigned PH_W   = QUO_W + N_HI_W;
  localparam int unsigned PL_W   = QUO_W + N_LO_W;
  localparam int unsigned RN_W   = QUO_W + N_W;
  localparam int unsigned RN_SH  = 2 * WORK_BITS - 2 * FRAC_BITS;

  logic              r_vld_q;
  logic [PH_W-1:0]   r_hu_q, r_hv_q;
  logic [PL_W-1:0]   r_lu_q, r_lv_q;
  logic              r_neg_u_q, r_neg_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= l_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_hu_q    <= l_qu_q * l_n_q[N_W-1:N_LO_W];
      r_lu_q    <= l_qu_q * l_n_q[N_LO_W-1:0];
      r_hv_q    <= l_qv_q * l_n_q[N_W-1:N_LO_W];
      r_lv_q    <= l_qv_q * l_n_q[N_LO_W-1:0];
      r_neg_u_q <= l_neg_u_q;
      r_neg_v_q <= l_neg_v_q;
    end
  end

  logic              x_vld_q;
  pgg_sqrt_t         x_dat_q, x_dat_d;
  logic [RN_W-1:0]   rn_u, rn_v;

  always_comb begin
    rn_u = (RN_W'(r_hu_q) << N_LO_W) + RN_W'(r_lu_q);
    rn_v = (RN_W'(r_hv_q) << N_LO_W) + RN_W'(r_lv_q);
    x_dat_d.rad_u  = RAD_W'(rn_u >> RN_SH);
    x_dat_d.rad_v  = RAD_W'(rn_v >> RN_SH);
    x_dat_d.root_u = '0;
    x_dat_d.root_v = '0;
    x_dat_d.neg_u  = r_neg_u_q;
    x_dat_d.neg_v  = r_neg_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_vld_q <= 1'b0;
    end else if (en) begin
      x_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_dat_q <= x_dat_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 36..55: floor square root, one root bit per stage, MSB first.
  // ---------------------------------------------------------------------
  logic      sq_vld [ROOT_W+1];
  pgg_sqrt_t sq_dat [ROOT_W+1];

  assign sq_vld[0] = x_vld_q;
  assign sq_dat[0] = x_dat_q;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    pgg_sqrt_stage #(.BIT(ROOT_W - 1 - g)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[g]),
      .dat_i  (sq_dat[g]),
      .vld_o  (sq_vld[g+1]),
      .dat_o  (sq_dat[g+1])
    );
  end

  pgg_sqrt_t sq_end;
  assign sq_end = sq_dat[ROOT_W];

  // ---------------------------------------------------------------------
  // Stage 56: scale by std_scale.
  // ---------------------------------------------------------------------
  localparam int unsigned T_W = 32 + ROOT_W - FRAC_BITS;

  logic                  t_vld_q;
  logic [T_W-1:0]        t_u_q, t_v_q;
  logic                  t_neg_u_q, t_neg_v_q;
  logic [32+ROOT_W-1:0]  sc_u, sc_v;

  assign sc_u = std_q * sq_end.root_u;
  assign sc_v = std_q * sq_end.root_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else if (en) begin
      t_vld_q <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_u_q     <= sc_u[32+ROOT_W-1:FRAC_BITS];
      t_v_q     <= sc_v[32+ROOT_W-1:FRAC_BITS];
      t_neg_u_q <= sq_end.neg_u;
      t_neg_v_q <= sq_end.neg_v;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 57: apply sign, add mean, saturate to 32 bits.
  // ---------------------------------------------------------------------
  localparam int unsigned SUM_W = T_W + 2;

  logic signed [31:0]    o_gu_q, o_gv_q;
  logic signed [SUM_W-1:0] sum_u, sum_v;
  logic signed [SUM_W-1:0] mean_x;
  logic signed [SUM_W-1:0] tu_x, tv_x;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'(32'sh7fffffff);
    lo = -hi - SUM_W'(1);
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  always_comb begin
    mean_x = SUM_W'(mean_q);
    tu_x   = $signed({2'b00, t_u_q});
    tv_x   = $signed({2'b00, t_v_q});
    sum_u  = t_neg_u_q ? (mean_x - tu_x) : (mean_x + tu_x);
    sum_v  = t_neg_v_q ? (mean_x - tv_x) : (mean_x + tv_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en) begin
      o_vld_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_gu_q <= sat32(sum_u);
      o_gv_q <= sat32(sum_v);
    end
  end

  // ---------------------------------------------------------------------
  // Output buffer: u item first, then v item flagged last.
  // ---------------------------------------------------------------------
  pgg_pair_out u_pair_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_vld_i  (o_vld_q),
    .gu_i        (o_gu_q),
    .gv_i        (o_gv_q),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

[bench/polar_gaussian_generator_core_tb.sv]
// Testbench: polar Gaussian generator core checked item by item against a bit-exact predictor.
`timescale 1ns / 1ps

module polar_gaussian_generator_core_tb;
  import pgg_pkg::*;

  // Write to an index the block does not decode; it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
  // Idle cycles the watchdog tolerates before it declares a hang.
  localparam int unsigned HANG_LIMIT = 5000;
  // Pipe depth plus margin.  Rejected pairs leave no result, so this long
  // a wait is needed before the pipe is known to be empty.
  localparam int unsigned DRAIN_CYCLES = 70;
  localparam int unsigned RAND_ITEMS = 1250;

  // How a directed row is checked:
  //   CHK_PRED   - expected results come from the predictor
  //   CHK_REJECT - the pair lies outside the unit circle, no result at all
  //   CHK_MEAN   - zero scale, both results equal mean_offset
  typedef enum logic [1:0] {CHK_PRED, CHK_REJECT, CHK_MEAN} chk_e;

  typedef struct packed {
    logic [15:0] u_w;
    logic [15:0] v_w;
    chk_e        chk;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pgg_in_t              in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  pgg_out_t             out_item_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  // Predictor's copy of the two registers.
  longint          mean_q;
  longint unsigned scale_q;

  pgg_out_t gauss_fifo[$];   // results still owed by the block
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;

  always #1 clk_i = ~clk_i;

  polar_gaussian_generator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Uniform word onto [-1,1] with FRAC_BITS fraction bits, round to nearest.
  function automatic longint map_word(logic [15:0] w);
    longint unsigned m, wl, a, q;
    m  = (64'd1 << UNIFORM_BITS) - 1;
    wl = w;
    if (2 * wl >= m) begin
      a = 2 * wl - m;
      q = ((a << (FRAC_BITS + 1)) + m) / (2 * m);
      return longint'(q);
    end
    a = m - 2 * wl;
    q = ((a << (FRAC_BITS + 1)) + m) / (2 * m);
    return -longint'(q);
  endfunction

  // floor(a * 2^WORK_BITS / b), restoring division, a <= b.
  function automatic longint unsigned frac_quotient(longint unsigned a,
                                                    longint unsigned b);
    longint unsigned q, rem;
    q   = 0;
    rem = a;
    if (rem >= b) begin
      rem = rem - b;
      q   = 1;
    end
    for (int i = 0; i < WORK_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // -2 ln s, WORK_BITS fraction bits, via log2 by repeated squaring.
  function automatic longint unsigned neg_two_ln(longint unsigned s);
    int p;
    longint unsigned m, frac, l2;
    p    = 0;
    frac = 0;
    while (p < 63 && (s >> (p + 1)) != 0) p++;
    if (p <= WORK_BITS) m = s << (WORK_BITS - p);
    else m = s >> (p - WORK_BITS);
    for (int i = 1; i <= WORK_BITS; i++) begin
      m = (m * m) >> WORK_BITS;
      if (m >= (64'd2 << WORK_BITS)) begin
        m    = m >> 1;
        frac = frac | (64'd1 << (WORK_BITS - i));
      end
    end
    l2 = (longint'(2 * FRAC_BITS - p) << WORK_BITS) - frac;
    return (l2 * 64'd186065279) >> (WORK_BITS - 1);
  endfunction

  // mean + std * x * f, saturated to 32 bits.
  function automatic logic [31:0] gauss_term(longint x, longint unsigned s,
                                             longint unsigned n);
    longint unsigned mag, r, g, t;
    longint sum;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    r   = frac_quotient(mag * mag, s);
    g   = int_sqrt((r * n) >> (2 * WORK_BITS - 2 * FRAC_BITS));
    t   = (scale_q * g) >> FRAC_BITS;
    sum = mean_q + ((x < 0) ? -longint'(t) : longint'(t));
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // Queue up what one accepted pair must produce.
  task automatic predict_pair(pgg_in_t it, chk_e chk);
    longint u, v;
    longint unsigned au, av, s, n;
    pgg_out_t res;
    u  = map_word(it.u_sample);
    v  = map_word(it.v_sample);
    au = (u < 0) ? longint'(-u) : longint'(u);
    av = (v < 0) ? longint'(-v) : longint'(v);
    s  = au * au + av * av;
    if (chk == CHK_REJECT) return;
    if (chk == CHK_MEAN) begin
      res.gauss_value  = mean_q[31:0];
      res.last_of_pair = 1'b0;
      gauss_fifo.push_back(res);
      res.last_of_pair = 1'b1;
      gauss_fifo.push_back(res);
      return;
    end
    if (s == 0 || s >= (64'd1 << (2 * FRAC_BITS))) return;
    n = neg_two_ln(s);
    res.gauss_value  = gauss_term(u, s, n);
    res.last_of_pair = 1'b0;
    gauss_fifo.push_back(res);
    res.gauss_value  = gauss_term(v, s, n);
    res.last_of_pair = 1'b1;
    gauss_fifo.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Sampled at the rising edge; the DUT's registers have not moved yet.
  always @(posedge clk_i) begin
    pgg_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (gauss_fifo.size() == 0) begin
        report($sformatf("unexpected item value %h last %b",
                         out_item_o.gauss_value, out_item_o.last_of_pair));
      end else begin
        want = gauss_fifo.pop_front();
        if (out_item_o.gauss_value !== want.gauss_value)
          report($sformatf("gauss_value %h, want %h",
                           out_item_o.gauss_value, want.gauss_value));
        if (out_item_o.last_of_pair !== want.last_of_pair)
          report($sformatf("last_of_pair %b, want %b",
                           out_item_o.last_of_pair, want.last_of_pair));
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= HANG_LIMIT) begin
      $display("polar_gaussian_generator_core_tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Receiver stall: a new stall density whenever stall_tick wraps, including none.
  int unsigned stall_pct = 0;
  int unsigned stall_tick = 0;
  always @(negedge clk_i) begin
    if (stall_tick == 0) begin
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_tick  = (stall_tick + 1) % 64;
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic send_pair(pgg_in_t it, chk_e chk);
    in_item_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_pair(it, chk);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MEAN_OFFSET) mean_q = longint'($signed(data));
    else if (idx == REG_STD_SCALE) scale_q = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // All owed items in, then let rejected pairs still in flight fall out.
  task automatic drain();
    while (gauss_fifo.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] mean, logic [31:0] scale);
    drain();
    write_reg(REG_MEAN_OFFSET, mean);
    write_reg(REG_STD_SCALE, scale);
  endtask

  // Random pair: mostly uniform words, some pressed to the edges of the
  // square, near the center, or near the unit circle.
  function automatic pgg_in_t rand_pair();
    pgg_in_t it;
    int unsigned w;
    it.u_sample = 16'($urandom);
    it.v_sample = 16'($urandom);
    case ($urandom_range(9))
      0: begin
        it.u_sample = $urandom_range(1) ? 16'($urandom_range(255))
                                        : 16'(32'hFFFF - $urandom_range(255));
      end
      1: begin
        it.u_sample = 16'(32'h8000 - $urandom_range(64));
        it.v_sample = 16'(32'h7FFF + $urandom_range(64));
      end
      2: begin
        // about 1/sqrt(2) from center in each axis, right at the circle
        w = $urandom_range(64);
        it.u_sample = $urandom_range(1) ? 16'(32'd55937 + w - 32) : 16'(32'd9598 + w - 32);
        it.v_sample = $urandom_range(1) ? 16'(32'd55937 - w + 32) : 16'(32'd9598 - w + 32);
      end
      default: ;
    endcase
    return it;
  endfunction

  // Random traffic in bursts; some bursts back to back with no gap.
  task automatic rand_phase(int unsigned items);
    int unsigned left, burst;
    left = items;
    while (left != 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_pair(rand_pair(), CHK_PRED);
      left = left - burst;
      if ($urandom_range(3) != 0) repeat ($urandom_range(10)) @(negedge clk_i);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed stimulus
  // ---------------------------------------------------------------------------

  // Reset registers: corners of the square are outside the circle and
  // vanish; the center words give the smallest s and the largest log.
  dir_row_t dir_tab[14] = '{
    '{16'h0000, 16'h0000, CHK_REJECT},
    '{16'hFFFF, 16'hFFFF, CHK_REJECT},
    '{16'h0000, 16'h8000, CHK_REJECT},
    '{16'hFFFF, 16'h7FFF, CHK_REJECT},
    '{16'h7FFF, 16'h8000, CHK_PRED},
    '{16'h8000, 16'h8000, CHK_PRED},
    '{16'h7FFF, 16'h7FFF, CHK_PRED},
    '{16'hFFFE, 16'h8000, CHK_PRED},
    '{16'h0001, 16'h7FFF, CHK_PRED},
    '{16'hBFFF, 16'h8000, CHK_PRED},
    '{16'h4000, 16'hBFFF, CHK_PRED},
    '{16'hDA80, 16'hDA80, CHK_PRED},
    '{16'hAAAA, 16'h5555, CHK_PRED},
    '{16'h5555, 16'hAAAA, CHK_PRED}
  };

  // Zero scale: every kept pair yields mean_offset twice.
  dir_row_t zero_tab[4] = '{
    '{16'h8000, 16'h8000, CHK_MEAN},
    '{16'hBFFF, 16'h4000, CHK_MEAN},
    '{16'hFFFE, 16'h7FFF, CHK_MEAN},
    '{16'hFFFF, 16'h0000, CHK_REJECT}
  };

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_MEAN_OFFSET;
    cfg_data_i  = '0;
    mean_q      = 0;
    scale_q     = 64'd1 << FRAC_BITS;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values of the registers are checked by the first table.
    foreach (dir_tab[i]) begin
      send_pair({dir_tab[i].u_w, dir_tab[i].v_w}, dir_tab[i].chk);
      repeat ($urandom_range(3)) @(negedge clk_i);
    end

    set_regs(32'h1234_0000, 32'h0000_0000);
    foreach (zero_tab[i]) send_pair({zero_tab[i].u_w, zero_tab[i].v_w}, zero_tab[i].chk);

    // An undecoded index must leave both registers alone.
    drain();
    write_reg(REG_UNUSED, $urandom);

    // Random phases across register settings, extremes included.
    set_regs(32'h0000_0000, 32'h0001_0000);
    rand_phase(RAND_ITEMS / 5);
    // Sender holds off until the pipe has delivered everything.
    while (gauss_fifo.size() != 0) @(negedge clk_i);
    rand_phase(RAND_ITEMS / 10);
    set_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF);   // saturates high
    rand_phase(RAND_ITEMS / 5);
    set_regs(32'h8000_0000, 32'hFFFF_FFFF);   // saturates low
    rand_phase(RAND_ITEMS / 5);
    set_regs($urandom, $urandom);
    rand_phase(RAND_ITEMS / 10);
    set_regs($urandom, $urandom_range(32'h0004_0000));
    rand_phase(RAND_ITEMS / 5);

    drain();
    if (err_cnt == 0) begin
      $display("polar_gaussian_generator_core_tb: clean");
    end else begin
      $display("polar_gaussian_generator_core_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pgg_pkg.sv
hdl/pgg_log_div_stage.sv
hdl/pgg_sqrt_stage.sv
hdl/pgg_pair_out.sv
hdl/polar_gaussian_generator_core.sv
bench/polar_gaussian_generator_core_tb.sv
